### rtl/line_edit_ring_buffer_macros.svh
// assertion macros for the line edit ring buffer
// expects clk_i and rst_ni in the scope of the module that uses them
`ifndef LINE_EDIT_RING_BUFFER_MACROS_SVH
`define LINE_EDIT_RING_BUFFER_MACROS_SVH

// property checked on every clock edge outside reset
`define LERB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication checked outside reset
`define LERB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

`endif

### rtl/lerb_pkg.sv
// shared types, character codes and command/status structs of the line edit ring buffer
// no dependencies
package lerb_pkg;

  // default number of entries in the character store
  localparam int unsigned BUF_DEPTH_DEF = 64;

  // control characters
  localparam logic [7:0] CH_KILL = 8'h15;
  localparam logic [7:0] CH_BS   = 8'h08;
  localparam logic [7:0] CH_EOF  = 8'h04;
  localparam logic [7:0] CH_DEL  = 8'h7F;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;

  // request function codes
  localparam logic FUNC_RX   = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  // echo kinds
  localparam logic [1:0] ECHO_NONE  = 2'd0;
  localparam logic [1:0] ECHO_CHAR  = 2'd1;
  localparam logic [1:0] ECHO_ERASE = 2'd2;

  // read status codes
  localparam logic [1:0] RS_NONE  = 2'd0;
  localparam logic [1:0] RS_BYTE  = 2'd1;
  localparam logic [1:0] RS_EOF   = 2'd2;
  localparam logic [1:0] RS_EMPTY = 2'd3;

  // input request payload
  typedef struct packed {
    logic       func;
    logic [7:0] rx_char;
    logic       read_first;
  } lerb_in_t;

  // result payload
  typedef struct packed {
    logic [1:0] echo_kind;
    logic [7:0] echo_char;
    logic [1:0] read_status;
    logic [7:0] read_data;
    logic       line_committed;
    logic       last;
  } lerb_out_t;

  // store read address source
  typedef enum logic {
    RD_AT_READ,
    RD_BEFORE_EDIT
  } rd_sel_e;

  // edit pointer update
  typedef enum logic [1:0] {
    EDIT_HOLD,
    EDIT_INC,
    EDIT_DEC
  } edit_op_e;

  // commands from controller to datapath
  typedef struct packed {
    logic       latch;
    logic       mem_rd;
    rd_sel_e    rd_sel;
    logic       mem_wr;
    edit_op_e   edit_op;
    logic       commit;
    logic       read_inc;
    logic       out_load;
    logic [1:0] echo_kind;
    logic [1:0] read_status;
    logic       last;
  } lerb_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic func_read;
    logic first;
    logic is_kill;
    logic is_erase;
    logic empty;
    logic no_edit;
    logic room;
    logic store_commit;
    logic dec_eq_commit;
    logic rd_is_lf;
    logic rd_is_eof;
    logic out_free;
  } lerb_sts_t;

endpackage

### rtl/lerb_dp.sv
// datapath of the line edit ring buffer: character store, pointers, output register
// depends on lerb_pkg and line_edit_ring_buffer_macros.svh
`include "line_edit_ring_buffer_macros.svh"

module lerb_dp #(
  parameter int unsigned BUF_DEPTH = lerb_pkg::BUF_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lerb_pkg::lerb_in_t  in_data_i,
  input  logic                out_ready_i,
  input  lerb_pkg::lerb_cmd_t cmd_i,
  output lerb_pkg::lerb_sts_t sts_o,
  output logic                out_valid_o,
  output lerb_pkg::lerb_out_t out_data_o
);

  localparam int unsigned IDX_W = $clog2(BUF_DEPTH);
  localparam int unsigned PTR_W = $clog2(2 * BUF_DEPTH);
  localparam logic [PTR_W-1:0] DEPTH_P = PTR_W'(BUF_DEPTH);
  localparam logic [PTR_W-1:0] FULL_M1 = PTR_W'(BUF_DEPTH - 1);
  localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(2 * BUF_DEPTH - 1);
  localparam logic [PTR_W:0]   SPAN    = (PTR_W + 1)'(2 * BUF_DEPTH);

  // pointer arithmetic modulo twice the depth
  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_MAX) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
    return (p == '0) ? PTR_MAX : p - 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] ptr_dist(input logic [PTR_W-1:0] a,
                                                input logic [PTR_W-1:0] b);
    logic [PTR_W:0] diff;
    if (a >= b) begin
      diff = {1'b0, a} - {1'b0, b};
    end else begin
      diff = SPAN - ({1'b0, b} - {1'b0, a});
    end
    return diff[PTR_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] slot(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] s;
    s = (p >= DEPTH_P) ? p - DEPTH_P : p;
    return s[IDX_W-1:0];
  endfunction

  lerb_pkg::lerb_in_t  item_q;
  logic [PTR_W-1:0]    rd_ptr_q, cm_ptr_q, ed_ptr_q;
  logic [PTR_W-1:0]    ed_inc, ed_dec, dist_er, dist_cr;
  logic [7:0]          mem_q [BUF_DEPTH];
  logic [7:0]          rdata_q;
  logic [7:0]          mapped;
  logic [IDX_W-1:0]    rd_addr, wr_addr;
  logic                out_valid_q;
  lerb_pkg::lerb_out_t out_q, out_d;

  // latched request
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      item_q <= in_data_i;
    end
  end

  // pointer neighbors and fill levels
  assign ed_inc  = ptr_inc(ed_ptr_q);
  assign ed_dec  = ptr_dec(ed_ptr_q);
  assign dist_er = ptr_dist(ed_ptr_q, rd_ptr_q);
  assign dist_cr = ptr_dist(cm_ptr_q, rd_ptr_q);

  // carriage return is stored as line feed
  assign mapped = (item_q.rx_char == lerb_pkg::CH_CR) ? lerb_pkg::CH_LF : item_q.rx_char;

  // status toward the controller
  always_comb begin
    sts_o.func_read     = (item_q.func == lerb_pkg::FUNC_READ);
    sts_o.first         = item_q.read_first;
    sts_o.is_kill       = (item_q.rx_char == lerb_pkg::CH_KILL);
    sts_o.is_erase      = (item_q.rx_char == lerb_pkg::CH_BS) ||
                          (item_q.rx_char == lerb_pkg::CH_DEL);
    sts_o.empty         = (rd_ptr_q == cm_ptr_q);
    sts_o.no_edit       = (ed_ptr_q == cm_ptr_q);
    sts_o.room          = (dist_er < DEPTH_P);
    sts_o.store_commit  = (mapped == lerb_pkg::CH_LF) || (mapped == lerb_pkg::CH_EOF) ||
                          (dist_er == FULL_M1);
    sts_o.dec_eq_commit = (ed_dec == cm_ptr_q);
    sts_o.rd_is_lf      = (rdata_q == lerb_pkg::CH_LF);
    sts_o.rd_is_eof     = (rdata_q == lerb_pkg::CH_EOF);
    sts_o.out_free      = !out_valid_q || out_ready_i;
  end

  // character store, one write and one registered read
  assign rd_addr = (cmd_i.rd_sel == lerb_pkg::RD_AT_READ) ? slot(rd_ptr_q) : slot(ed_dec);
  assign wr_addr = slot(ed_ptr_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_wr) begin
      mem_q[wr_addr] <= mapped;
    end
    if (cmd_i.mem_rd) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  // read, commit and edit pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      cm_ptr_q <= '0;
      ed_ptr_q <= '0;
    end else begin
      if (cmd_i.read_inc) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (cmd_i.commit) begin
        cm_ptr_q <= ed_inc;
      end
      case (cmd_i.edit_op)
        lerb_pkg::EDIT_INC: ed_ptr_q <= ed_inc;
        lerb_pkg::EDIT_DEC: ed_ptr_q <= ed_dec;
        default:            ed_ptr_q <= ed_ptr_q;
      endcase
    end
  end

  // result payload
  always_comb begin
    out_d.echo_kind      = cmd_i.echo_kind;
    out_d.echo_char      = (cmd_i.echo_kind == lerb_pkg::ECHO_CHAR) ? mapped : 8'd0;
    out_d.read_status    = cmd_i.read_status;
    out_d.read_data      = (cmd_i.read_status == lerb_pkg::RS_BYTE) ? rdata_q : 8'd0;
    out_d.line_committed = cmd_i.commit;
    out_d.last           = cmd_i.last;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // checks
  `LERB_ASSERT(a_fill_bound, dist_er <= DEPTH_P, "edit pointer more than a buffer ahead")
  `LERB_ASSERT(a_commit_order, dist_cr <= dist_er, "commit pointer passed edit pointer")
  `LERB_ASSERT_IMP(a_no_overwrite, cmd_i.mem_wr, sts_o.room, "store written while full")
  `LERB_ASSERT_IMP(a_load_free, cmd_i.out_load, !out_valid_q || out_ready_i,
                   "result loaded over a pending result")

endmodule

### rtl/lerb_ctrl.sv
// controller state machine of the line edit ring buffer
// depends on lerb_pkg
module lerb_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  lerb_pkg::lerb_sts_t sts_i,
  output lerb_pkg::lerb_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_RD_EVAL,
    ST_KILL_RD,
    ST_KILL_EVAL
  } state_e;

  state_e state_q, state_d;
  logic   pend_q, pend_d;

  // next state and commands
  always_comb begin
    state_d = state_q;
    pend_d  = pend_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.latch = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_DISPATCH;
        end
      end

      ST_DISPATCH: begin
        if (sts_i.out_free) begin
          if (sts_i.func_read) begin
            // read request
            if (sts_i.empty) begin
              cmd_o.out_load    = 1'b1;
              cmd_o.read_status = lerb_pkg::RS_EMPTY;
              cmd_o.last        = 1'b1;
              state_d           = ST_IDLE;
            end else begin
              cmd_o.mem_rd = 1'b1;
              cmd_o.rd_sel = lerb_pkg::RD_AT_READ;
              state_d      = ST_RD_EVAL;
            end
          end else if (sts_i.is_kill) begin
            // kill line
            if (sts_i.no_edit) begin
              cmd_o.out_load = 1'b1;
              cmd_o.last     = 1'b1;
              state_d        = ST_IDLE;
            end else begin
              pend_d  = 1'b0;
              state_d = ST_KILL_RD;
            end
          end else if (sts_i.is_erase) begin
            // erase one character
            cmd_o.out_load = 1'b1;
            cmd_o.last     = 1'b1;
            if (!sts_i.no_edit) begin
              cmd_o.edit_op   = lerb_pkg::EDIT_DEC;
              cmd_o.echo_kind = lerb_pkg::ECHO_ERASE;
            end
            state_d = ST_IDLE;
          end else begin
            // store and echo, dropped when full
            cmd_o.out_load = 1'b1;
            cmd_o.last     = 1'b1;
            if (sts_i.room) begin
              cmd_o.mem_wr    = 1'b1;
              cmd_o.edit_op   = lerb_pkg::EDIT_INC;
              cmd_o.commit    = sts_i.store_commit;
              cmd_o.echo_kind = lerb_pkg::ECHO_CHAR;
            end
            state_d = ST_IDLE;
          end
        end
      end

      ST_RD_EVAL: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.last     = 1'b1;
          if (sts_i.rd_is_eof) begin
            cmd_o.read_inc    = sts_i.first;
            cmd_o.read_status = lerb_pkg::RS_EOF;
          end else begin
            cmd_o.read_inc    = 1'b1;
            cmd_o.read_status = lerb_pkg::RS_BYTE;
          end
          state_d = ST_IDLE;
        end
      end

      ST_KILL_RD: begin
        // fetch the character before the edit pointer
        cmd_o.mem_rd = 1'b1;
        cmd_o.rd_sel = lerb_pkg::RD_BEFORE_EDIT;
        state_d      = ST_KILL_EVAL;
      end

      ST_KILL_EVAL: begin
        if (sts_i.out_free) begin
          if (pend_q) begin
            // owed erase, last when a newline stops the walk
            cmd_o.out_load  = 1'b1;
            cmd_o.echo_kind = lerb_pkg::ECHO_ERASE;
            cmd_o.last      = sts_i.rd_is_lf;
            pend_d          = 1'b0;
            if (sts_i.rd_is_lf) begin
              state_d = ST_IDLE;
            end
          end else if (sts_i.rd_is_lf) begin
            // line already ends at a newline
            cmd_o.out_load = 1'b1;
            cmd_o.last     = 1'b1;
            state_d        = ST_IDLE;
          end else begin
            cmd_o.edit_op = lerb_pkg::EDIT_DEC;
            if (sts_i.dec_eq_commit) begin
              cmd_o.out_load  = 1'b1;
              cmd_o.echo_kind = lerb_pkg::ECHO_ERASE;
              cmd_o.last      = 1'b1;
              state_d         = ST_IDLE;
            end else begin
              pend_d  = 1'b1;
              state_d = ST_KILL_RD;
            end
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
    end
  end

endmodule

### rtl/line_edit_ring_buffer.sv
// top level of the cooked-mode console line edit ring buffer
// depends on lerb_pkg, lerb_ctrl and lerb_dp
//
// Cooked-mode console input: each request is a received character or a read of one
// committed byte, and produces one or more results (echo and/or read response), the
// final one flagged by last. A read takes longer than a character or an erase,
// since the character store has a registered read port. Kill-line erases one
// character at a time (store read, pointer step, result), up to BUF_DEPTH-1
// characters. A new request is taken while the last result still waits in the
// output register; results stall the engine only when that register is still
// full.
module line_edit_ring_buffer #(
  parameter int unsigned BUF_DEPTH = lerb_pkg::BUF_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  lerb_pkg::lerb_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output lerb_pkg::lerb_out_t out_data_o
);

  lerb_pkg::lerb_cmd_t cmd;
  lerb_pkg::lerb_sts_t sts;

  // controller
  lerb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath
  lerb_dp #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_ready_i (out_ready_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

### tb/testbench.sv
// self-checking testbench for the cooked-mode line edit ring buffer
// depends on lerb_pkg and line_edit_ring_buffer; runs a directed table, then random traffic
// with its own prediction of echoes, erases, commits and read responses
module testbench;

  localparam int unsigned DEPTH        = lerb_pkg::BUF_DEPTH_DEF;
  localparam int unsigned PW           = $clog2(DEPTH) + 1;
  localparam int unsigned NUM_ROWS     = 25;
  localparam int unsigned RANDOM_ITEMS = 250;
  localparam int unsigned HOLD_CYCLES  = 150;
  localparam int unsigned DRAIN_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  typedef logic [PW-1:0] ptr_t;

  // one directed request, with a typed result where it is obvious
  typedef struct {
    lerb_pkg::lerb_in_t  req;
    bit                  typed;
    lerb_pkg::lerb_out_t res;
  } step_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  lerb_pkg::lerb_in_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  lerb_pkg::lerb_out_t out_data;

  // traffic shaping shared by sender and receiver
  bit gaps_on = 1'b1;
  bit stall_on = 1'b1;
  bit hold_req = 1'b0;

  // line discipline state as predicted
  logic [7:0]          line_store [DEPTH];
  ptr_t                reader_at, commit_at, cursor_at;
  lerb_pkg::lerb_out_t cooked [$];
  lerb_pkg::lerb_out_t results_due [$];
  lerb_pkg::lerb_out_t want_res;

  step_row_t  dir_rows [NUM_ROWS];

  int unsigned n_items = 0, n_results = 0, n_errors = 0, n_cycles = 0;
  int unsigned n_erases = 0, n_commits = 0, n_eofs = 0;

  line_edit_ring_buffer uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  always #6 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", n_cycles, results_due.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic lerb_pkg::lerb_in_t mk_req(logic f, logic [7:0] ch, logic first);
    lerb_pkg::lerb_in_t q;
    q.func       = f;
    q.rx_char    = ch;
    q.read_first = first;
    return q;
  endfunction

  function automatic step_row_t row(logic f, logic [7:0] ch, logic first, bit typed,
                                    logic [1:0] ek, logic [7:0] ec, logic [1:0] rs,
                                    logic [7:0] rd, logic com);
    step_row_t r;
    r.req                = mk_req(f, ch, first);
    r.typed              = typed;
    r.res.echo_kind      = ek;
    r.res.echo_char      = ec;
    r.res.read_status    = rs;
    r.res.read_data      = rd;
    r.res.line_committed = com;
    r.res.last           = 1'b1;
    return r;
  endfunction

  // results of one request, appended to cooked; advances the predicted state
  task automatic cook_input(input lerb_pkg::lerb_in_t req);
    lerb_pkg::lerb_out_t r;
    logic [7:0]          ch;
    logic [7:0]          b;
    ptr_t                prev;
    int unsigned         n;
    r  = '0;
    ch = req.rx_char;
    n  = 0;
    if (req.func == lerb_pkg::FUNC_READ) begin
      if (reader_at == commit_at) begin
        r.read_status = lerb_pkg::RS_EMPTY;
      end else begin
        b = line_store[reader_at % DEPTH];
        if (b == lerb_pkg::CH_EOF) begin
          // end of input is consumed only at the start of a read call
          if (req.read_first) reader_at = reader_at + 1'b1;
          r.read_status = lerb_pkg::RS_EOF;
        end else begin
          reader_at     = reader_at + 1'b1;
          r.read_status = lerb_pkg::RS_BYTE;
          r.read_data   = b;
        end
      end
      cooked.push_back(r);
    end else if (ch == lerb_pkg::CH_KILL) begin
      // erase the open line back to the commit point or a newline
      forever begin
        prev = cursor_at - 1'b1;
        if (n >= DEPTH || cursor_at == commit_at ||
            line_store[prev % DEPTH] == lerb_pkg::CH_LF) break;
        cursor_at   = prev;
        r.echo_kind = lerb_pkg::ECHO_ERASE;
        cooked.push_back(r);
        n++;
      end
    end else if (ch == lerb_pkg::CH_BS || ch == lerb_pkg::CH_DEL) begin
      if (cursor_at != commit_at) begin
        cursor_at   = cursor_at - 1'b1;
        r.echo_kind = lerb_pkg::ECHO_ERASE;
        cooked.push_back(r);
      end
    end else if (ptr_t'(cursor_at - reader_at) < DEPTH) begin
      // store and echo, carriage return becomes newline
      if (ch == lerb_pkg::CH_CR) ch = lerb_pkg::CH_LF;
      line_store[cursor_at % DEPTH] = ch;
      cursor_at   = cursor_at + 1'b1;
      r.echo_kind = lerb_pkg::ECHO_CHAR;
      r.echo_char = ch;
      if (ch == lerb_pkg::CH_LF || ch == lerb_pkg::CH_EOF ||
          ptr_t'(cursor_at - reader_at) == DEPTH) begin
        commit_at        = cursor_at;
        r.line_committed = 1'b1;
      end
      cooked.push_back(r);
    end
    // dropped or nothing to erase
    if (cooked.size() == 0) begin
      r = '0;
      cooked.push_back(r);
    end
    r      = cooked.pop_back();
    r.last = 1'b1;
    cooked.push_back(r);
  endtask

  // offer one request and queue its results once accepted
  task automatic offer(input lerb_pkg::lerb_in_t req, input bit typed,
                       input lerb_pkg::lerb_out_t want);
    while (gaps_on && $urandom_range(99) < 36) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    n_items++;
    cooked.delete();
    cook_input(req);
    if (typed) begin
      cooked.delete();
      cooked.push_back(want);
    end
    foreach (cooked[i]) results_due.push_back(cooked[i]);
    @(negedge clk);
  endtask

  task automatic send_char(input logic [7:0] ch);
    offer(mk_req(lerb_pkg::FUNC_RX, ch, 1'($urandom)), 1'b0, '0);
  endtask

  // one read call of several single-byte requests
  task automatic read_call(input int unsigned count);
    for (int unsigned i = 0; i < count; i++)
      offer(mk_req(lerb_pkg::FUNC_READ, 8'($urandom), i == 0), 1'b0, '0);
  endtask

  // a typed line with some editing and a random terminator
  task automatic type_line(input int unsigned len);
    int unsigned pick;
    for (int unsigned i = 0; i < len; i++) begin
      pick = $urandom_range(99);
      if (pick < 6) send_char(lerb_pkg::CH_BS);
      else if (pick < 10) send_char(lerb_pkg::CH_DEL);
      else if (pick < 12) send_char(lerb_pkg::CH_KILL);
      else send_char(8'($urandom_range(8'h7E, 8'h20)));
    end
    // a long line is sometimes wiped before it ends
    if (len > 40 && $urandom_range(1) == 1) send_char(lerb_pkg::CH_KILL);
    pick = $urandom_range(99);
    if (pick < 40) send_char(lerb_pkg::CH_LF);
    else if (pick < 75) send_char(lerb_pkg::CH_CR);
    else if (pick < 90) send_char(lerb_pkg::CH_EOF);
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (results_due.size() != 0);
  endtask

  task automatic match_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      n_errors++;
    end
  endtask

  // receiver: random stalls and one long hold-off
  initial begin : receiver
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_ready <= !(stall_on && $urandom_range(99) < 36);
    end
  end

  // result checking against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        $error("result with no request pending: %p", out_data);
        n_errors++;
      end else begin
        want_res = results_due.pop_front();
        n_results++;
        if (want_res.echo_kind == lerb_pkg::ECHO_ERASE) n_erases++;
        if (want_res.line_committed) n_commits++;
        if (want_res.read_status == lerb_pkg::RS_EOF) n_eofs++;
        match_field("echo_kind", want_res.echo_kind, out_data.echo_kind);
        match_field("echo_char", want_res.echo_char, out_data.echo_char);
        match_field("read_status", want_res.read_status, out_data.read_status);
        match_field("read_data", want_res.read_data, out_data.read_data);
        match_field("line_committed", want_res.line_committed, out_data.line_committed);
        match_field("last", want_res.last, out_data.last);
      end
    end
  end

  initial begin : stimulus
    int unsigned pick, len, start;
    bit          hold_used, pause_used;
    hold_used  = 1'b0;
    pause_used = 1'b0;
    reader_at  = '0;
    commit_at  = '0;
    cursor_at  = '0;

    // directed table: empty store, erase on nothing, extremes, newline mapping, end of input
    dir_rows = '{
      row(lerb_pkg::FUNC_READ, 8'hA5, 1'b1, 1'b1, lerb_pkg::ECHO_NONE, 8'h00,
          lerb_pkg::RS_EMPTY, 8'h00, 1'b0),
      row(lerb_pkg::FUNC_RX, lerb_pkg::CH_BS, 1'b0, 1'b1, lerb_pkg::ECHO_NONE, 8'h00,
          lerb_pkg::RS_NONE, 8'h00, 1'b0),
      row(lerb_pkg::FUNC_RX, lerb_pkg::CH_DEL, 1'b1, 1'b1, lerb_pkg::ECHO_NONE, 8'h00,
          lerb_pkg::RS_NONE, 8'h00, 1'b0),
      row(lerb_pkg::FUNC_RX, lerb_pkg::CH_KILL, 1'b0, 1'b1, lerb_pkg::ECHO_NONE, 8'h00,
          lerb_pkg::RS_NONE, 8'h00, 1'b0),
      row(lerb_pkg::FUNC_RX, 8'h61, 1'b1, 1'b1, lerb_pkg::ECHO_CHAR, 8'h61,
          lerb_pkg::RS_NONE, 8'h00, 1'b0),
      row(lerb_pkg::FUNC_RX, 8'hFF, 1'b0, 1'b1, lerb_pkg::ECHO_CHAR, 8'hFF,
          lerb_pkg::RS_NONE, 8'h00, 1'b0),
      row(lerb_pkg::FUNC_RX, lerb_pkg::CH_DEL, 1'b0, 1'b1, lerb_pkg::ECHO_ERASE, 8'h00,
          lerb_pkg::RS_NONE, 8'h00, 1'b0),
      row(lerb_pkg::FUNC_RX, 8'h00, 1'b1, 1'b1, lerb_pkg::ECHO_CHAR, 8'h00,
          lerb_pkg::RS_NONE, 8'h00, 1'b0),
      row(lerb_pkg::FUNC_RX, lerb_pkg::CH_KILL, 1'b1, 1'b0, lerb_pkg::ECHO_NONE, 8'h00,
          lerb_pkg::RS_NONE, 8'h00, 1'b0),
      row(lerb_pkg::FUNC_RX, 8'h78, 1'b0, 1'b1, lerb_pkg::ECHO_CHAR, 8'h78,
          lerb_pkg::RS_NONE, 8'h00, 1'b0),
      row(lerb_pkg::FUNC_RX, lerb_pkg::CH_CR, 1'b0, 1'b1, lerb_pkg::ECHO_CHAR, lerb_pkg::CH_LF,
          lerb_pkg::RS_NONE, 8'h00, 1'b1),
      row(lerb_pkg::FUNC_READ, 8'h5A, 1'b1, 1'b1, lerb_pkg::ECHO_NONE, 8'h00,
          lerb_pkg::RS_BYTE, 8'h78, 1'b0),
      row(lerb_pkg::FUNC_READ, 8'hFF, 1'b0, 1'b1, lerb_pkg::ECHO_NONE, 8'h00,
          lerb_pkg::RS_BYTE, lerb_pkg::CH_LF, 1'b0),
      row(lerb_pkg::FUNC_READ, 8'h00, 1'b1, 1'b1, lerb_pkg::ECHO_NONE, 8'h00,
          lerb_pkg::RS_EMPTY, 8'h00, 1'b0),
      row(lerb_pkg::FUNC_RX, lerb_pkg::CH_BS, 1'b1, 1'b1, lerb_pkg::ECHO_NONE, 8'h00,
          lerb_pkg::RS_NONE, 8'h00, 1'b0),
      row(lerb_pkg::FUNC_RX, 8'h71, 1'b0, 1'b0, lerb_pkg::ECHO_NONE, 8'h00,
          lerb_pkg::RS_NONE, 8'h00, 1'b0),
      row(lerb_pkg::FUNC_RX, lerb_pkg::CH_EOF, 1'b0, 1'b1, lerb_pkg::ECHO_CHAR, lerb_pkg::CH_EOF,
          lerb_pkg::RS_NONE, 8'h00, 1'b1),
      row(lerb_pkg::FUNC_READ, 8'h0F, 1'b0, 1'b0, lerb_pkg::ECHO_NONE, 8'h00,
          lerb_pkg::RS_NONE, 8'h00, 1'b0),
      row(lerb_pkg::FUNC_READ, 8'hF0, 1'b0, 1'b1, lerb_pkg::ECHO_NONE, 8'h00,
          lerb_pkg::RS_EOF, 8'h00, 1'b0),
      row(lerb_pkg::FUNC_READ, 8'h33, 1'b0, 1'b1, lerb_pkg::ECHO_NONE, 8'h00,
          lerb_pkg::RS_EOF, 8'h00, 1'b0),
      row(lerb_pkg::FUNC_READ, 8'hCC, 1'b1, 1'b1, lerb_pkg::ECHO_NONE, 8'h00,
          lerb_pkg::RS_EOF, 8'h00, 1'b0),
      row(lerb_pkg::FUNC_READ, 8'h00, 1'b1, 1'b1, lerb_pkg::ECHO_NONE, 8'h00,
          lerb_pkg::RS_EMPTY, 8'h00, 1'b0),
      row(lerb_pkg::FUNC_RX, lerb_pkg::CH_LF, 1'b1, 1'b1, lerb_pkg::ECHO_CHAR, lerb_pkg::CH_LF,
          lerb_pkg::RS_NONE, 8'h00, 1'b1),
      row(lerb_pkg::FUNC_RX, lerb_pkg::CH_KILL, 1'b0, 1'b1, lerb_pkg::ECHO_NONE, 8'h00,
          lerb_pkg::RS_NONE, 8'h00, 1'b0),
      row(lerb_pkg::FUNC_READ, 8'h81, 1'b0, 1'b0, lerb_pkg::ECHO_NONE, 8'h00,
          lerb_pkg::RS_NONE, 8'h00, 1'b0)
    };

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int unsigned i = 0; i < NUM_ROWS; i++)
      offer(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);

    // random part: mostly edited lines followed by read calls, with noise
    start = n_items;
    while (n_items < start + RANDOM_ITEMS) begin
      // first stretch of the random part runs with no idling on either side
      gaps_on  = (n_items >= start + 50);
      stall_on = gaps_on;
      if (!hold_used && n_items >= start + 60) begin
        hold_req  = 1'b1;
        hold_used = 1'b1;
      end
      if (!pause_used && n_items >= start + 100) begin
        wait_all_results();
        pause_used = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 60) begin
        len = ($urandom_range(99) < 10) ? $urandom_range(70, 50) : $urandom_range(12, 0);
        type_line(len);
        if ($urandom_range(99) < 80) read_call($urandom_range(len + 3, len / 2));
      end else if (pick < 75) begin
        read_call($urandom_range(6, 1));
      end else if (pick < 90) begin
        offer(mk_req(lerb_pkg::FUNC_RX, 8'($urandom), 1'($urandom)), 1'b0, '0);
      end else begin
        offer(mk_req(1'($urandom), 8'($urandom), 1'($urandom)), 1'b0, '0);
      end
    end

    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d requests, %0d results checked: %0d erase echoes, %0d commits, %0d eof reads",
             n_items, n_results, n_erases, n_commits, n_eofs);
    $display("covered editing, kill-line, full and empty store, deferred eof and backpressure");
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
